// ===== src/bfa_pkg.sv =====
// shared constants, types and codes of the best-fit block allocator
package bfa_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int HEADER_BYTES     = 24;
   localparam int BACKPTR_BYTES    = 8;

   localparam int OPCODE_W = 2;
   localparam int WORD_W   = 32;
   localparam int ALIGN_W  = 13;
   localparam int COUNT_W  = 7;
   localparam int CSR_IDX_W = 2;
   localparam int PAD_W    = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 2'd2;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_NOFIT    = 2'd1,
      STS_NOTFOUND = 2'd2,
      STS_NULLFREE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_WR_NEW,
      S_WR_PICK,
      S_WR_MERGE,
      S_STATS,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] start;
      logic [WORD_W-1:0] size;
      logic              used;
      logic [WORD_W-1:0] payload;
   } seg_type;

   typedef struct packed {
      logic       init;
      logic       csr_we;
      logic       accept;
      logic       status_set;
      status_type status_code;
      logic       scan_start;
      logic       scan_run;
      logic       decide;
      logic       shift_start;
      logic       shift_run;
      logic       stats_start;
      logic       stats_run;
      logic       wr_new;
      logic       wr_pick;
      logic       wr_merge;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic found;
      logic is_alloc;
      logic split;
      logic merge_any;
      logic rsp_busy;
   } sts_type;

endpackage

// ===== src/bfa_ctrl.sv =====
// sequencer of the allocator: scan, split or merge, table shift and statistics pass
module bfa_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bfa_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [bfa_pkg::WORD_W-1:0]     req_free_address,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bfa_pkg::CSR_IDX_W-1:0]  csr_index,
   output bfa_pkg::cmd_type               cmd,
   input  bfa_pkg::sts_type               sts
);
   import bfa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.status_code = STS_OK;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            csr_ready = 1'b1;
            req_stall = csr_valid;
            if (csr_valid) begin
               cmd.csr_we = 1'b1;
               if (csr_index == CSR_POOL) begin
                  state_in = S_INIT;
               end
            end else if (req_valid) begin
               cmd.accept     = 1'b1;
               cmd.status_set = 1'b1;
               if (opcode_type'(req_opcode) == OP_ALLOC ||
                   (opcode_type'(req_opcode) == OP_FREE && req_free_address != '0)) begin
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end else begin
                  if (opcode_type'(req_opcode) == OP_FREE) begin
                     cmd.status_code = STS_NULLFREE;
                  end
                  cmd.stats_start = 1'b1;
                  state_in = S_STATS;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.sweep_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            if (!sts.found) begin
               cmd.status_set  = 1'b1;
               cmd.status_code = sts.is_alloc ? STS_NOFIT : STS_NOTFOUND;
               cmd.stats_start = 1'b1;
               state_in = S_STATS;
            end else if (!sts.is_alloc) begin
               state_in = S_WR_MERGE;
            end else if (sts.split) begin
               cmd.shift_start = 1'b1;
               state_in = S_SHIFT;
            end else begin
               state_in = S_WR_PICK;
            end
         end
         S_SHIFT: begin
            cmd.shift_run = 1'b1;
            if (sts.sweep_done) begin
               if (sts.is_alloc) begin
                  state_in = S_WR_NEW;
               end else begin
                  cmd.cnt_dec     = 1'b1;
                  cmd.stats_start = 1'b1;
                  state_in = S_STATS;
               end
            end
         end
         S_WR_NEW: begin
            cmd.wr_new  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in = S_WR_PICK;
         end
         S_WR_PICK: begin
            cmd.wr_pick     = 1'b1;
            cmd.stats_start = 1'b1;
            state_in = S_STATS;
         end
         S_WR_MERGE: begin
            cmd.wr_merge = 1'b1;
            if (sts.merge_any) begin
               cmd.shift_start = 1'b1;
               state_in = S_SHIFT;
            end else begin
               cmd.stats_start = 1'b1;
               state_in = S_STATS;
            end
         end
         S_STATS: begin
            cmd.stats_run = 1'b1;
            if (sts.sweep_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule

// ===== src/bfa_datapath.sv =====
// segment table memory, sweep pointer, fit and merge arithmetic and result registers
module bfa_datapath #(
   parameter int MAX_SEGMENTS = bfa_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bfa_pkg::cmd_type               cmd,
   output bfa_pkg::sts_type               sts,
   input  logic [bfa_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [bfa_pkg::WORD_W-1:0]     req_request_size,
   input  logic [bfa_pkg::WORD_W-1:0]     req_free_address,
   input  logic [bfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfa_pkg::WORD_W-1:0]     csr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [bfa_pkg::WORD_W-1:0]     rsp_payload_address,
   output logic [bfa_pkg::WORD_W-1:0]     rsp_used_bytes,
   output logic [bfa_pkg::COUNT_W-1:0]    rsp_segment_count,
   output logic [bfa_pkg::COUNT_W-1:0]    rsp_free_segment_count
);
   import bfa_pkg::*;

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);

   function automatic logic [PAD_W-1:0] pad_of(input logic [WORD_W-1:0] start,
                                                input logic [ALIGN_W-1:0] align);
      logic [ALIGN_W-1:0]  a;
      logic [WORD_W+1:0]   m;
      logic [WORD_W+1:0]   base;
      logic [WORD_W+1:0]   al;
      logic [WORD_W+1:0]   diff;
      a    = (align == '0) ? ALIGN_W'(1) : align;
      m    = (WORD_W+2)'(a - ALIGN_W'(1));
      base = {2'b00, start} + (WORD_W+2)'(HEADER_BYTES);
      al   = (base + (WORD_W+2)'(BACKPTR_BYTES) + m) & ~m;
      diff = al - base;
      return diff[PAD_W-1:0];
   endfunction

   seg_type            seg_mem_ff [MAX_SEGMENTS];
   seg_type            rd_data_ff;
   logic [IW-1:0]      rd_idx_ff;
   logic               rd_vld_ff;
   logic [CW-1:0]      ptr_ff;
   logic [CW-1:0]      ptr_in;

   logic [WORD_W-1:0]  pool_ff;
   logic [ALIGN_W-1:0] align_ff;
   logic               policy_ff;
   logic [CW-1:0]      count_ff;

   opcode_type         op_ff;
   logic [WORD_W-1:0]  req_ff;
   logic [WORD_W-1:0]  faddr_ff;
   status_type         status_ff;
   logic [WORD_W-1:0]  addr_ff;

   logic               found_ff;
   logic [IW-1:0]      pick_ff;
   seg_type            pick_ent_ff;
   logic [PAD_W-1:0]   pick_pad_ff;
   seg_type            prev_ent_ff;
   seg_type            last_ent_ff;
   logic               left_free_ff;
   logic               right_free_ff;
   logic [WORD_W-1:0]  next_size_ff;
   logic               split_ff;

   logic [WORD_W-1:0]  used_sum_ff;
   logic [CW-1:0]      nfree_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [WORD_W-1:0]  rsp_addr_ff;
   logic [WORD_W-1:0]  rsp_used_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [COUNT_W-1:0] rsp_nfree_ff;

   logic               is_alloc;
   logic               run;
   logic               ins;
   logic               iss;
   logic [PAD_W-1:0]   cur_pad;
   logic [WORD_W:0]    need;
   logic               fits;
   logic               take_alloc;
   logic               take_free;
   logic               next_hit;
   logic               split_c;
   logic [CW-1:0]      rm_from;
   logic [IW-1:0]      k_dec;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   seg_type            wr_data;
   logic [WORD_W-1:0]  pick_payload;
   logic [CW+COUNT_W-1:0] cnt_x;
   logic [CW+COUNT_W-1:0] nfree_x;

   assign is_alloc = (op_ff == OP_ALLOC);
   assign run      = cmd.scan_run | cmd.stats_run | cmd.shift_run;
   assign ins      = cmd.shift_run & is_alloc;
   assign iss      = run & (ins ? (ptr_ff > CW'(pick_ff)) : (ptr_ff < count_ff));

   assign cur_pad    = pad_of(rd_data_ff.start, align_ff);
   assign need       = {1'b0, req_ff} + (WORD_W+1)'(cur_pad);
   assign fits       = !rd_data_ff.used && ({1'b0, rd_data_ff.size} >= need);
   assign take_alloc = cmd.scan_run & rd_vld_ff & is_alloc & fits &
                       (!found_ff || (!policy_ff && rd_data_ff.size < pick_ent_ff.size));
   assign take_free  = cmd.scan_run & rd_vld_ff & !is_alloc & !found_ff &
                       rd_data_ff.used & (rd_data_ff.payload == faddr_ff);
   assign next_hit   = cmd.scan_run & rd_vld_ff & !is_alloc & found_ff &
                       ({1'b0, rd_idx_ff} == ({1'b0, pick_ff} + 1'b1));

   assign split_c = ({2'b00, pick_ent_ff.size} >=
                     {2'b00, req_ff} + (WORD_W+2)'(pick_pad_ff) +
                     (WORD_W+2)'(HEADER_BYTES)) &&
                    (count_ff < CW'(MAX_SEGMENTS));

   assign rm_from = CW'(pick_ff) + (right_free_ff ? CW'(2) : CW'(1));
   assign k_dec   = (left_free_ff && right_free_ff) ? IW'(2) : IW'(1);
   assign pick_payload = pick_ent_ff.start + WORD_W'(HEADER_BYTES) + WORD_W'(pick_pad_ff);

   always_comb begin
      if (cmd.scan_start || cmd.stats_start) begin
         ptr_in = '0;
      end else if (cmd.shift_start) begin
         ptr_in = is_alloc ? (count_ff - CW'(1)) : rm_from;
      end else if (iss) begin
         ptr_in = ins ? (ptr_ff - CW'(1)) : (ptr_ff + CW'(1));
      end else begin
         ptr_in = ptr_ff;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = rd_data_ff;
      if (cmd.init) begin
         wr_en           = 1'b1;
         wr_addr         = '0;
         wr_data.start   = '0;
         wr_data.size    = (pool_ff >= WORD_W'(HEADER_BYTES)) ?
                           (pool_ff - WORD_W'(HEADER_BYTES)) : '0;
         wr_data.used    = 1'b0;
         wr_data.payload = '0;
      end else if (cmd.shift_run && rd_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = ins ? (rd_idx_ff + IW'(1)) : (rd_idx_ff - k_dec);
      end else if (cmd.wr_new) begin
         wr_en           = 1'b1;
         wr_addr         = pick_ff + IW'(1);
         wr_data.start   = pick_payload + req_ff;
         wr_data.size    = pick_ent_ff.size - req_ff - WORD_W'(pick_pad_ff) -
                           WORD_W'(HEADER_BYTES);
         wr_data.used    = 1'b0;
         wr_data.payload = '0;
      end else if (cmd.wr_pick) begin
         wr_en           = 1'b1;
         wr_addr         = pick_ff;
         wr_data.start   = pick_ent_ff.start;
         wr_data.size    = split_ff ? (req_ff + WORD_W'(pick_pad_ff)) : pick_ent_ff.size;
         wr_data.used    = 1'b1;
         wr_data.payload = pick_payload;
      end else if (cmd.wr_merge) begin
         wr_en = 1'b1;
         if (left_free_ff) begin
            wr_addr         = pick_ff - IW'(1);
            wr_data         = prev_ent_ff;
            wr_data.size    = prev_ent_ff.size + pick_ent_ff.size + WORD_W'(HEADER_BYTES) +
                              (right_free_ff ? (next_size_ff + WORD_W'(HEADER_BYTES)) : '0);
         end else begin
            wr_addr         = pick_ff;
            wr_data         = pick_ent_ff;
            wr_data.size    = pick_ent_ff.size +
                              (right_free_ff ? (next_size_ff + WORD_W'(HEADER_BYTES)) : '0);
         end
         wr_data.used = 1'b0;
      end
   end

   // segment table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         seg_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= seg_mem_ff[ptr_ff[IW-1:0]];
      rd_idx_ff  <= ptr_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= WORD_W'(65536);
         align_ff     <= ALIGN_W'(8);
         policy_ff    <= 1'b0;
         count_ff     <= CW'(1);
         rd_vld_ff    <= 1'b0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff <= ptr_in;
         if (cmd.scan_start || cmd.stats_start || cmd.shift_start) begin
            rd_vld_ff <= 1'b0;
         end else begin
            rd_vld_ff <= iss;
         end
         if (cmd.csr_we) begin
            unique case (csr_index)
               CSR_POOL:   pool_ff   <= csr_data;
               CSR_ALIGN:  align_ff  <= csr_data[ALIGN_W-1:0];
               CSR_POLICY: policy_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.init) begin
            count_ff <= CW'(1);
         end else if (cmd.cnt_inc) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - CW'(k_dec);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign cnt_x   = {{COUNT_W{1'b0}}, count_ff};
   assign nfree_x = {{COUNT_W{1'b0}}, nfree_ff};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= opcode_type'(req_opcode);
         req_ff   <= req_request_size;
         faddr_ff <= req_free_address;
         addr_ff  <= '0;
      end
      if (cmd.status_set) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.scan_start) begin
         found_ff      <= 1'b0;
         left_free_ff  <= 1'b0;
         right_free_ff <= 1'b0;
      end
      if (cmd.scan_run && rd_vld_ff) begin
         last_ent_ff <= rd_data_ff;
      end
      if (take_alloc || take_free) begin
         found_ff    <= 1'b1;
         pick_ff     <= rd_idx_ff;
         pick_ent_ff <= rd_data_ff;
         pick_pad_ff <= cur_pad;
      end
      if (take_free) begin
         left_free_ff <= (rd_idx_ff != '0) && !last_ent_ff.used;
         prev_ent_ff  <= last_ent_ff;
      end
      if (next_hit) begin
         right_free_ff <= !rd_data_ff.used;
         next_size_ff  <= rd_data_ff.size;
      end
      if (cmd.decide) begin
         split_ff <= split_c;
      end
      if (cmd.wr_pick) begin
         addr_ff <= pick_payload;
      end
      if (cmd.stats_start) begin
         used_sum_ff <= '0;
         nfree_ff    <= '0;
      end else if (cmd.stats_run && rd_vld_ff) begin
         if (rd_data_ff.used) begin
            used_sum_ff <= used_sum_ff + rd_data_ff.size;
         end else begin
            nfree_ff <= nfree_ff + CW'(1);
         end
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_addr_ff   <= addr_ff;
         rsp_used_ff   <= used_sum_ff;
         rsp_count_ff  <= cnt_x[COUNT_W-1:0];
         rsp_nfree_ff  <= nfree_x[COUNT_W-1:0];
      end
   end

   assign sts.sweep_done = run & !iss & !rd_vld_ff;
   assign sts.found      = found_ff;
   assign sts.is_alloc   = is_alloc;
   assign sts.split      = split_c;
   assign sts.merge_any  = left_free_ff | right_free_ff;
   assign sts.rsp_busy   = rsp_valid_ff & rsp_stall;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_payload_address    = rsp_addr_ff;
   assign rsp_used_bytes         = rsp_used_ff;
   assign rsp_segment_count      = rsp_count_ff;
   assign rsp_free_segment_count = rsp_nfree_ff;

endmodule

// ===== src/best_fit_block_allocator_unit.sv =====
// top level of the best-fit block allocator with coalescing
//
//  channel | direction | signals                                    | transfer when
//  req     | in        | opcode, request_size, free_address         | req_valid & !req_stall
//  rsp     | out       | status, payload_address, used_bytes, counts | rsp_valid & !rsp_stall
//  csr     | in        | index, data                                | csr_valid & csr_ready
//
//  one operation at a time; every sweep reads one table entry per cycle
//  allocate: accept, scan, decide, on a split a table shift and two writes (else one
//  write), statistics pass, result load; free: the same with one merge write, then a shift
//  if a neighbour merged; query, unused opcode and null free: accept, statistics pass, result load
//  after reset and after each pool size write, the init state writes the first table entry
//  a result held by rsp_stall stays in the output register; the next result waits behind it
module best_fit_block_allocator_unit #(
   parameter int MAX_SEGMENTS = bfa_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bfa_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [bfa_pkg::WORD_W-1:0]     req_request_size,
   input  logic [bfa_pkg::WORD_W-1:0]     req_free_address,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [bfa_pkg::WORD_W-1:0]     rsp_payload_address,
   output logic [bfa_pkg::WORD_W-1:0]     rsp_used_bytes,
   output logic [bfa_pkg::COUNT_W-1:0]    rsp_segment_count,
   output logic [bfa_pkg::COUNT_W-1:0]    rsp_free_segment_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfa_pkg::WORD_W-1:0]     csr_data
);
   import bfa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bfa_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_free_address (req_free_address),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .cmd              (cmd),
      .sts              (sts)
   );

   bfa_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_opcode             (req_opcode),
      .req_request_size       (req_request_size),
      .req_free_address       (req_free_address),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_payload_address    (rsp_payload_address),
      .rsp_used_bytes         (rsp_used_bytes),
      .rsp_segment_count      (rsp_segment_count),
      .rsp_free_segment_count (rsp_free_segment_count)
   );

endmodule

// ===== src/bfa_checker.sv =====
// port-level checks of the allocator and their binding to the top level
module bfa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [1:0]                     rsp_status,
   input logic [bfa_pkg::WORD_W-1:0]     rsp_payload_address,
   input logic [bfa_pkg::COUNT_W-1:0]    rsp_segment_count,
   input logic [bfa_pkg::COUNT_W-1:0]    rsp_free_segment_count
);
   import bfa_pkg::*;

   // held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // failed operations report no address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status_type'(rsp_status) != STS_OK) |-> rsp_payload_address == '0)
      else $error("address on a failed operation");

   // free segments are a subset of the table
   a_free_le: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_segment_count <= rsp_segment_count)
      else $error("free count above segment count");

   // the table never empties
   a_count_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_segment_count != '0)
      else $error("empty segment table");

endmodule

bind best_fit_block_allocator_unit bfa_checker u_bfa_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_status             (rsp_status),
   .rsp_payload_address    (rsp_payload_address),
   .rsp_segment_count      (rsp_segment_count),
   .rsp_free_segment_count (rsp_free_segment_count)
);

// ===== test/testbench.sv =====
// self-checking testbench for the best-fit block allocator with coalescing
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bfa_pkg::*;

   localparam int SEGS = MAX_SEGMENTS_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      status_type       status;
      logic [31:0]      address;
      logic [31:0]      used;
      logic [COUNT_W-1:0] segs;
      logic [COUNT_W-1:0] frees;
   } result_type;

   typedef struct {
      opcode_type  op;
      logic [31:0] size;
      logic [31:0] addr;
      bit          typed;
      result_type  want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [OPCODE_W-1:0] req_opcode = '0;
   logic [WORD_W-1:0] req_request_size = '0;
   logic [WORD_W-1:0] req_free_address = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [WORD_W-1:0] rsp_payload_address;
   logic [WORD_W-1:0] rsp_used_bytes;
   logic [COUNT_W-1:0] rsp_segment_count;
   logic [COUNT_W-1:0] rsp_free_segment_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0] csr_data = '0;

   best_fit_block_allocator_unit uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   longint unsigned pool_size = 65536;
   longint unsigned align_cfg = 8;
   bit first_fit = 1'b0;
   longint unsigned seg_start [SEGS];
   longint unsigned seg_size [SEGS];
   bit seg_used [SEGS];
   longint unsigned seg_payload [SEGS];
   int seg_total;

   result_type pending [$];
   int errors = 0;
   int checked = 0;
   int n_alloc_ok = 0, n_nofit = 0, n_free_ok = 0, n_notfound = 0, n_null = 0;
   int burst_left = 0;
   int gap_max = 6;

   function automatic void rebuild_table();
      for (int i = 0; i < SEGS; i++) begin
         seg_start[i] = 0;
         seg_size[i] = 0;
         seg_used[i] = 0;
         seg_payload[i] = 0;
      end
      seg_size[0] = pool_size >= HEADER_BYTES ? pool_size - HEADER_BYTES : 0;
      seg_total = 1;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
         CSR_POOL: begin
            pool_size = val;
            rebuild_table();
         end
         CSR_ALIGN: align_cfg = val & 32'h1FFF;
         CSR_POLICY: first_fit = val[0];
         default: ;
      endcase
   endfunction

   function automatic longint unsigned pad_for(int i);
      longint unsigned a, base, al;
      a = align_cfg ? align_cfg : 1;
      base = seg_start[i] + HEADER_BYTES;
      al = (base + BACKPTR_BYTES + (a - 1)) & ~(a - 1);
      return al - base;
   endfunction

   function automatic void shift_up(int pos);
      for (int i = seg_total; i > pos; i--) begin
         seg_start[i] = seg_start[i-1];
         seg_size[i] = seg_size[i-1];
         seg_used[i] = seg_used[i-1];
         seg_payload[i] = seg_payload[i-1];
      end
      seg_total++;
   endfunction

   function automatic void shift_down(int pos);
      for (int i = pos; i + 1 < seg_total; i++) begin
         seg_start[i] = seg_start[i+1];
         seg_size[i] = seg_size[i+1];
         seg_used[i] = seg_used[i+1];
         seg_payload[i] = seg_payload[i+1];
      end
      seg_total--;
   endfunction

   function automatic result_type predict_op(opcode_type op, logic [31:0] sz,
                                             logic [31:0] fa);
      result_type r;
      longint unsigned req, pad, used;
      int pick, nfree, i;
      bit found;
      req = sz;
      r.status = STS_OK;
      r.address = '0;
      if (op == OP_ALLOC) begin
         found = 0;
         pick = 0;
         for (i = 0; i < seg_total; i++) begin
            if (!seg_used[i] && seg_size[i] >= req + pad_for(i)) begin
               if (!found || seg_size[i] < seg_size[pick]) begin
                  pick = i;
                  found = 1;
               end
               if (first_fit) break;
            end
         end
         if (!found) r.status = STS_NOFIT;
         else begin
            pad = pad_for(pick);
            if (seg_size[pick] >= req + pad + HEADER_BYTES && seg_total < SEGS) begin
               shift_up(pick + 1);
               seg_start[pick+1] = seg_start[pick] + HEADER_BYTES + pad + req;
               seg_size[pick+1] = seg_size[pick] - req - pad - HEADER_BYTES;
               seg_used[pick+1] = 0;
               seg_payload[pick+1] = 0;
               seg_size[pick] = req + pad;
            end
            seg_used[pick] = 1;
            seg_payload[pick] = seg_start[pick] + HEADER_BYTES + pad;
            r.address = seg_payload[pick][31:0];
         end
      end else if (op == OP_FREE) begin
         if (fa == 0) r.status = STS_NULLFREE;
         else begin
            for (i = 0; i < seg_total; i++)
               if (seg_used[i] && seg_payload[i] == fa) break;
            if (i >= seg_total) r.status = STS_NOTFOUND;
            else begin
               seg_used[i] = 0;
               if (i > 0 && !seg_used[i-1]) begin
                  seg_size[i-1] += seg_size[i] + HEADER_BYTES;
                  shift_down(i);
                  i--;
               end
               if (i + 1 < seg_total && !seg_used[i+1]) begin
                  seg_size[i] += seg_size[i+1] + HEADER_BYTES;
                  shift_down(i + 1);
               end
            end
         end
      end
      used = 0;
      nfree = 0;
      for (i = 0; i < seg_total; i++)
         if (seg_used[i]) used += seg_size[i];
         else nfree++;
      r.used = used[31:0];
      r.segs = seg_total[COUNT_W-1:0];
      r.frees = nfree[COUNT_W-1:0];
      return r;
   endfunction

   // result checking and receiver stall pattern
   int stall_mode = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, status %0d addr %h", $time, rsp_status,
                     rsp_payload_address);
         end else begin
            e = pending.pop_front();
            if (rsp_status !== e.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
            end
            if (rsp_payload_address !== e.address) begin
               errors++;
               $display("%0t: payload_address expected %h actual %h", $time, e.address,
                        rsp_payload_address);
            end
            if (rsp_used_bytes !== e.used) begin
               errors++;
               $display("%0t: used_bytes expected %0d actual %0d", $time, e.used,
                        rsp_used_bytes);
            end
            if (rsp_segment_count !== e.segs) begin
               errors++;
               $display("%0t: segment_count expected %0d actual %0d", $time, e.segs,
                        rsp_segment_count);
            end
            if (rsp_free_segment_count !== e.frees) begin
               errors++;
               $display("%0t: free_segment_count expected %0d actual %0d", $time, e.frees,
                        rsp_free_segment_count);
            end
         end
      end
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(50, 300);
      end else stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: rsp_stall <= ((stall_left % 40) < 18);
      endcase
   end

   task automatic issue(input opcode_type op, input logic [31:0] sz, input logic [31:0] fa,
                        input bit typed, input result_type want, output result_type got);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_request_size <= sz;
      req_free_address <= fa;
      do @(posedge clock); while (req_stall);
      got = predict_op(op, sz, fa);
      pending.push_back(typed ? want : got);
      case (got.status)
         STS_OK: if (op == OP_ALLOC) n_alloc_ok++; else if (op == OP_FREE) n_free_ok++;
         STS_NOFIT: n_nofit++;
         STS_NOTFOUND: n_notfound++;
         default: n_null++;
      endcase
      if (burst_left > 0) burst_left--;
      else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random(input int count, input longint unsigned cap);
      logic [31:0] live [$];
      logic [31:0] gone [$];
      result_type got, none;
      logic [31:0] sz, fa;
      int r, k;
      opcode_type op;
      none = '{status: STS_OK, default: '0};
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         sz = '0;
         fa = '0;
         if (r < 50 || (r < 80 && live.size() == 0)) begin
            op = OP_ALLOC;
            k = $urandom_range(0, 9);
            if (k < 7) sz = $urandom_range(0, cap);
            else if (k == 7) sz = $urandom();
            else if (k == 8) sz = '0;
            else sz = $urandom_range(0, pool_size > 32'hFFFFFFFF ? 32'hFFFFFFFF : pool_size);
         end else if (r < 80) begin
            op = OP_FREE;
            k = $urandom_range(0, live.size() - 1);
            fa = live[k];
         end else if (r < 86) begin
            op = OP_FREE;
            fa = gone.size() ? gone[$urandom_range(0, gone.size() - 1)] : $urandom();
         end else if (r < 91) begin
            op = OP_FREE;
            fa = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom();
         end else if (r < 96) begin
            op = OP_QUERY;
            sz = $urandom();
            fa = $urandom();
         end else begin
            op = OP_NONE;
            sz = $urandom();
            fa = $urandom();
         end
         if (n == count / 2) drain();
         issue(op, sz, fa, 1'b0, none, got);
         if (op == OP_ALLOC && got.status == STS_OK) live.push_back(got.address);
         if (op == OP_FREE && got.status == STS_OK) begin
            foreach (live[i])
               if (live[i] == fa) begin
                  live.delete(i);
                  break;
               end
            gone.push_back(fa);
            if (gone.size() > 16) void'(gone.pop_front());
         end
      end
      drain();
   endtask

   task automatic run_phase(input logic [31:0] pool, input logic [31:0] align,
                            input bit policy, input int count, input longint unsigned cap,
                            input int gaps);
      drain();
      repeat (4) @(posedge clock);
      write_csr(CSR_POOL, pool);
      write_csr(CSR_ALIGN, align);
      write_csr(CSR_POLICY, {31'b0, policy});
      gap_max = gaps;
      run_random(count, cap);
   endtask

   stim_row_type directed [$];

   initial begin
      result_type got;
      result_type none;
      none = '{status: STS_OK, default: '0};
      rebuild_table();
      directed = '{
         '{OP_QUERY, 32'h0, 32'h0, 1, '{STS_OK, 32'h0, 32'h0, 7'd1, 7'd1}},
         '{OP_FREE, 32'h0, 32'h0, 1, '{STS_NULLFREE, 32'h0, 32'h0, 7'd1, 7'd1}},
         '{OP_FREE, 32'h0, 32'hFFFF_FFFF, 1, '{STS_NOTFOUND, 32'h0, 32'h0, 7'd1, 7'd1}},
         '{OP_ALLOC, 32'hFFFF_FFFF, 32'h0, 1, '{STS_NOFIT, 32'h0, 32'h0, 7'd1, 7'd1}},
         '{OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{STS_OK, 32'h0, 32'h0, 7'd1, 7'd1}},
         '{OP_ALLOC, 32'h0, 32'h0, 1, '{STS_OK, 32'd32, 32'd8, 7'd2, 7'd1}},
         '{OP_ALLOC, 32'd100, 32'h0, 0, none},
         '{OP_ALLOC, 32'd1, 32'h0, 0, none},
         '{OP_FREE, 32'h0, 32'd64, 0, none},
         '{OP_FREE, 32'h0, 32'd64, 0, none},
         '{OP_FREE, 32'h0, 32'd32, 0, none},
         '{OP_ALLOC, 32'd40, 32'h0, 0, none},
         '{OP_ALLOC, 32'd30000, 32'h0, 0, none},
         '{OP_ALLOC, 32'd35000, 32'h0, 0, none},
         '{OP_ALLOC, 32'd65000, 32'h0, 0, none},
         '{OP_FREE, 32'h0, 32'd200, 0, none},
         '{OP_QUERY, 32'h0, 32'h0, 0, none}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);
      foreach (directed[i])
         issue(directed[i].op, directed[i].size, directed[i].addr, directed[i].typed,
               directed[i].want, got);
      drain();
      write_csr(CSR_SPARE, 32'hFFFF_FFFF);
      gap_max = 6;
      run_random(380, 400);
      run_phase(32'd4096, 32'd16, 1'b1, 250, 120, 1);
      run_phase(32'hFFFF_FFFF, 32'd4096, 1'b0, 250, 32'h0800_0000, 8);
      run_phase(32'd24, 32'd1, 1'b1, 100, 8, 4);
      run_phase(32'd10, 32'd0, 1'b0, 80, 4, 3);
      run_phase(32'd65536, 32'd12, 1'b1, 200, 600, 6);
      run_phase(32'd65536, 32'hFFFF_E020, 1'b0, 300, 300, 2);
      run_phase(32'd200000, 32'd4, 1'b0, 220, 5000, 10);
      repeat (400) @(posedge clock);
      $display("checked %0d results over 8 register settings", checked);
      $display("allocs ok %0d, no fit %0d, frees ok %0d, not found %0d, null/other %0d",
               n_alloc_ok, n_nofit, n_free_ok, n_notfound, n_null);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("timeout with %0d results outstanding", pending.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== best_fit_block_allocator_unit.f =====
src/bfa_pkg.sv
src/bfa_ctrl.sv
src/bfa_datapath.sv
src/best_fit_block_allocator_unit.sv
src/bfa_checker.sv
test/testbench.sv
